FILE: sv/cgp_pkg.sv
// ----------------------------------------------------------------------------
// cgp_pkg
// Shared types, constants and GF(4) helpers for the matrix group product unit.
// ----------------------------------------------------------------------------
package cgp_pkg;

  localparam int MAX_ELEMS = 64;
  localparam int MAX_DIM   = 4;
  localparam int ELEM_W    = 6;
  localparam int POS_W     = 4;
  localparam int ADDR_W    = ELEM_W + POS_W;
  localparam int DEPTH     = MAX_ELEMS * MAX_DIM * MAX_DIM;
  localparam int IDX_W     = 2;
  localparam int DIM_W     = 3;
  localparam int CNT_W     = 7;
  localparam int MOD_W     = 16;
  localparam int WORD_W    = 32;
  localparam int DSTEP_W   = 5;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODULUS = 2'd0;
  localparam logic [1:0] CFG_DIM     = 2'd1;
  localparam logic [1:0] CFG_COUNT   = 2'd2;

  localparam logic [MOD_W-1:0] GF_MODULUS = 16'd4;
  localparam logic [DIM_W-1:0] GF_DIM     = 3'd2;

  typedef struct packed {
    logic load;
    logic capture;
    logic rd_a;
    logic rd_b;
    logic mul;
    logic acc;
    logic l_adv;
    logic div_load;
    logic div_step;
    logic wr_prod;
    logic s_rd;
    logic e_adv;
    logic k_adv;
    logic res_zero;
    logic res_hit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic q_bad;
    logic l_last;
    logic use_div;
    logic div_last;
    logic pair_last;
    logic match;
    logic e_last;
    logic k_last;
    logic out_busy;
  } stat_t;

  function automatic logic [WORD_W-1:0] gf_mul(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
    logic [1:0] r;
    r = 2'd0;
    if (a > 32'd3 || b > 32'd3) return '1;
    case ({a[1:0], b[1:0]})
      4'b0101: r = 2'd1;
      4'b0110: r = 2'd2;
      4'b0111: r = 2'd3;
      4'b1001: r = 2'd2;
      4'b1010: r = 2'd3;
      4'b1011: r = 2'd1;
      4'b1101: r = 2'd3;
      4'b1110: r = 2'd1;
      4'b1111: r = 2'd2;
      default: r = 2'd0;
    endcase
    return {30'd0, r};
  endfunction

  function automatic logic [WORD_W-1:0] gf_add(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
    if (a > 32'd3 || b > 32'd3) return '1;
    return {30'd0, a[1:0] ^ b[1:0]};
  endfunction

endpackage

FILE: sv/cgp_ctrl.sv
// ----------------------------------------------------------------------------
// cgp_ctrl
// Sequencer for loads, dot products, remainder and the search over elements.
// ----------------------------------------------------------------------------
module cgp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_req,
  output logic           in_ready,
  input  cgp_pkg::stat_t stat,
  output cgp_pkg::cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CHECK = 12'b000000000010,
    S_RDA   = 12'b000000000100,
    S_RDB   = 12'b000000001000,
    S_MUL   = 12'b000000010000,
    S_ACC   = 12'b000000100000,
    S_DIVL  = 12'b000001000000,
    S_DIV   = 12'b000010000000,
    S_WRP   = 12'b000100000000,
    S_SRD   = 12'b001000000000,
    S_SCMP  = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_req == cgp_pkg::REQ_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.q_bad) begin
          cmd.res_zero = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_RDA;
        end
      end
      S_RDA: begin
        cmd.rd_a = 1'b1;
        state_next = S_RDB;
      end
      S_RDB: begin
        cmd.rd_b = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (!stat.l_last) begin
          cmd.l_adv = 1'b1;
          state_next = S_RDA;
        end else if (stat.use_div) begin
          state_next = S_DIVL;
        end else begin
          state_next = S_WRP;
        end
      end
      S_DIVL: begin
        cmd.div_load = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_WRP;
      end
      S_WRP: begin
        cmd.wr_prod = 1'b1;
        state_next = stat.pair_last ? S_SRD : S_RDA;
      end
      S_SRD: begin
        cmd.s_rd = 1'b1;
        state_next = S_SCMP;
      end
      S_SCMP: begin
        if (stat.match) begin
          if (stat.e_last) begin
            cmd.res_hit = 1'b1;
            state_next = S_DONE;
          end else begin
            cmd.e_adv = 1'b1;
            state_next = S_SRD;
          end
        end else if (stat.k_last) begin
          cmd.res_zero = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.k_adv = 1'b1;
          state_next = S_SRD;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/cgp_dp.sv
// ----------------------------------------------------------------------------
// cgp_dp
// Matrix store, multiply-accumulate, serial remainder, product buffer and
// element comparison.
// ----------------------------------------------------------------------------
module cgp_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  cgp_pkg::cmd_t                 cmd,
  output cgp_pkg::stat_t                stat,
  input  logic [cgp_pkg::ELEM_W-1:0]    in_left,
  input  logic [cgp_pkg::ELEM_W-1:0]    in_right,
  input  logic [cgp_pkg::POS_W-1:0]     in_pos,
  input  logic [cgp_pkg::WORD_W-1:0]    in_value,
  input  logic [cgp_pkg::MOD_W-1:0]     modulus,
  input  logic [cgp_pkg::DIM_W-1:0]     dim,
  input  logic [cgp_pkg::CNT_W-1:0]     count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cgp_pkg::CNT_W-1:0]     out_index
);

  logic [cgp_pkg::WORD_W-1:0] mem [cgp_pkg::DEPTH];
  logic [cgp_pkg::WORD_W-1:0] rdata;
  logic [cgp_pkg::ADDR_W-1:0] raddr;

  logic [cgp_pkg::WORD_W-1:0] prod [cgp_pkg::MAX_DIM*cgp_pkg::MAX_DIM];

  logic [cgp_pkg::ELEM_W-1:0] li, ri, k;
  logic [cgp_pkg::IDX_W-1:0]  i, j, l;
  logic [cgp_pkg::POS_W-1:0]  e, pa, pb, pij;
  logic [4:0]                 dd;
  logic                       gf;
  logic [cgp_pkg::WORD_W-1:0] a_reg, mprod, acc, pval;
  logic [cgp_pkg::WORD_W-1:0] mag;
  logic [cgp_pkg::MOD_W:0]    rem, rem_sh;
  logic                       neg;
  logic [cgp_pkg::DSTEP_W-1:0] dstep;
  logic [cgp_pkg::CNT_W-1:0]  res;

  assign dd  = 5'(dim) * 5'(dim);
  assign gf  = (modulus == cgp_pkg::GF_MODULUS) && (dim == cgp_pkg::GF_DIM);
  assign pa  = 4'(4'(i) * 4'(dim)) + 4'(l);
  assign pb  = 4'(4'(l) * 4'(dim)) + 4'(j);
  assign pij = 4'(4'(i) * 4'(dim)) + 4'(j);

  // Select read address
  always_comb begin
    raddr = '0;
    if (cmd.rd_a) raddr = {li, pa};
    else if (cmd.rd_b) raddr = {ri, pb};
    else if (cmd.s_rd) raddr = {k, e};
  end

  // Store write on load and registered read
  always_ff @(posedge clk) begin
    if (cmd.load && ({1'b0, in_pos} < dd)) begin
      mem[{in_left, in_pos}] <= in_value;
    end
    rdata <= mem[raddr];
  end

  // Status back to the sequencer
  assign rem_sh = {rem[cgp_pkg::MOD_W-1:0], mag[cgp_pkg::WORD_W-1]};
  always_comb begin
    stat.q_bad     = ({1'b0, li} >= count) || ({1'b0, ri} >= count);
    stat.l_last    = (3'(l) == dim - 3'd1);
    stat.use_div   = (modulus != '0) && !gf;
    stat.div_last  = (dstep == '1);
    stat.pair_last = (3'(i) == dim - 3'd1) && (3'(j) == dim - 3'd1);
    stat.match     = (rdata == prod[e]);
    stat.e_last    = (5'(e) == dd - 5'd1);
    stat.k_last    = (7'(k) == count - 7'd1);
    stat.out_busy  = out_valid && !out_ready;
  end

  assign pval = stat.use_div ? (neg ? (32'd0 - 32'(rem)) : 32'(rem)) : acc;

  // Advance counters, accumulate, divide and record products
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      li <= in_left;
      ri <= in_right;
      i <= '0;
      j <= '0;
      l <= '0;
      acc <= '0;
    end
    if (cmd.rd_b) a_reg <= rdata;
    if (cmd.mul) mprod <= gf ? cgp_pkg::gf_mul(a_reg, rdata) : a_reg * rdata;
    if (cmd.acc) acc <= gf ? cgp_pkg::gf_add(acc, mprod) : acc + mprod;
    if (cmd.l_adv) l <= l + 1'b1;
    if (cmd.div_load) begin
      neg   <= acc[cgp_pkg::WORD_W-1];
      mag   <= acc[cgp_pkg::WORD_W-1] ? (32'd0 - acc) : acc;
      rem   <= '0;
      dstep <= '0;
    end
    if (cmd.div_step) begin
      mag   <= {mag[cgp_pkg::WORD_W-2:0], 1'b0};
      rem   <= (rem_sh >= {1'b0, modulus}) ? rem_sh - {1'b0, modulus} : rem_sh;
      dstep <= dstep + 1'b1;
    end
    if (cmd.wr_prod) begin
      prod[pij] <= pval;
      l   <= '0;
      acc <= '0;
      if (3'(j) == dim - 3'd1) begin
        j <= '0;
        i <= i + 1'b1;
      end else begin
        j <= j + 1'b1;
      end
      k <= '0;
      e <= '0;
    end
    if (cmd.e_adv) e <= e + 1'b1;
    if (cmd.k_adv) begin
      k <= k + 1'b1;
      e <= '0;
    end
    if (cmd.res_zero) res <= '0;
    if (cmd.res_hit) res <= 7'(k) + 7'd1;
  end

  // Hold the result until the downstream transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_index <= res;
  end

endmodule

FILE: sv/matrix_group_cayley_product_top.sv
// Operation: a load writes one store entry; a query runs a multiply-accumulate
// per product entry (plus a serial remainder when a modulus applies), then
// compares entries in the search. Throughput: a load every cycle while idle;
// a query holds the input until its result sits in the output register.
// Reset: synchronous, active high; registers return to modulus 0, dimension 2,
// count 1; the matrix store is not cleared.
// ----------------------------------------------------------------------------
// matrix_group_cayley_product_top
// Product of two stored matrices looked up among all stored matrices.
// ----------------------------------------------------------------------------
module matrix_group_cayley_product_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // left_index, right_index, entry_pos, entry_value
  input  logic        s_tuser,  // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // product_index, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [cgp_pkg::MOD_W-1:0] modulus;
  logic [cgp_pkg::DIM_W-1:0] matrix_dim, dim_eff;
  logic [cgp_pkg::CNT_W-1:0] element_count, count_eff;
  logic [cgp_pkg::CNT_W-1:0] out_index;
  cgp_pkg::cmd_t  cmd;
  cgp_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus       <= '0;
      matrix_dim    <= 3'd2;
      element_count <= 7'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        cgp_pkg::CFG_MODULUS: modulus       <= cfg_data;
        cgp_pkg::CFG_DIM:     matrix_dim    <= cfg_data[cgp_pkg::DIM_W-1:0];
        cgp_pkg::CFG_COUNT:   element_count <= cfg_data[cgp_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp dimension and count to the store size
  always_comb begin
    dim_eff = matrix_dim;
    if (matrix_dim == '0) dim_eff = 3'd1;
    else if (matrix_dim > 3'(cgp_pkg::MAX_DIM)) dim_eff = 3'(cgp_pkg::MAX_DIM);
    count_eff = element_count;
    if (element_count > 7'(cgp_pkg::MAX_ELEMS)) count_eff = 7'(cgp_pkg::MAX_ELEMS);
  end

  cgp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_req   (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cgp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_left   (s_tdata[5:0]),
    .in_right  (s_tdata[11:6]),
    .in_pos    (s_tdata[15:12]),
    .in_value  (s_tdata[47:16]),
    .modulus   (modulus),
    .dim       (dim_eff),
    .count     (count_eff),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_index (out_index)
  );

  assign m_tdata = {1'b0, out_index};

endmodule
